// ===== rtl/rbd_pkg.sv =====
// ============================================================================
// rbd_pkg: shared types and constants for the ring buffer deque
// Operation and status codes, field widths, and the control structs that
// the top level broadcasts along the row of storage cells.
// ============================================================================
package rbd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int FILL_W = 5;
    localparam int KIND_W = 3;
    localparam int POS_W  = 4;
    localparam int STAT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_READ_POS   = 3'd4,
        KIND_CLEAR      = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Update command, valid for one cycle at a transfer
    typedef struct packed {
        logic              shift_up;    // push at front: take lower neighbor
        logic              shift_down;  // pop at front: take upper neighbor
        logic              load_back;   // push at back: cell at fill loads
        logic [FILL_W-1:0] fill;        // element count before the step
    } t_cell_ctrl;

    // Tap selection, driven from the registered post-step state
    typedef struct packed {
        logic              rd_en;       // read position succeeded
        logic [POS_W-1:0]  pos;
        logic [FILL_W-1:0] fill;        // element count after the step
    } t_sel_ctrl;

endpackage

// ===== rtl/rbd_cell.sv =====
// ============================================================================
// rbd_cell: one storage cell of the deque row
// Holds one element, shifts toward either neighbor or loads the pushed value,
// and offers its element on the read and back taps when selected.
// ============================================================================
module rbd_cell
    import rbd_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  t_sel_ctrl         i_sel,
    input  logic [DATA_W-1:0] i_push_value,
    input  logic [DATA_W-1:0] i_prev_data,
    input  logic [DATA_W-1:0] i_next_data,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_read_tap,
    output logic [DATA_W-1:0] o_back_tap
);

    localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(INDEX);
    localparam logic [FILL_W-1:0] NXT_IDX = FILL_W'(INDEX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_read_hit;
    logic              w_back_hit;

    // Pick next content: shift, load at back, or hold
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            n_data = i_prev_data;
        end else if (i_ctrl.shift_down) begin
            n_data = i_next_data;
        end else if (i_ctrl.load_back && (i_ctrl.fill == MY_IDX)) begin
            n_data = i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Drive taps only when this cell is the selected one
    assign w_read_hit = i_sel.rd_en && ({1'b0, i_sel.pos} == MY_IDX);
    assign w_back_hit = (i_sel.fill == NXT_IDX);

    assign o_data     = r_data;
    assign o_read_tap = w_read_hit ? r_data : '0;
    assign o_back_tap = w_back_hit ? r_data : '0;

endmodule

// ===== rtl/ring_buffer_deque_core.sv =====
// ============================================================================
// ring_buffer_deque_core: double-ended queue over a row of shifting cells
// The block takes a new item only in its idle state, so it cannot accept the
// next item until the result of the last is loaded into the output register;
// the cell update cycle is followed by the tap select cycle that builds it.
// Reset clears the element count, the sequencer and the output valid; cell
// contents are not reset and are never visible before they are written.
// ============================================================================
module ring_buffer_deque_core
    import rbd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] kind, [34:3] push_value, [38:35] position, [39] zero
    input  logic [39:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [33:2] read_value, [65:34] front_value,
    // [97:66] back_value, [102:98] count, [103] is_empty
    output logic [103:0] m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEL  = 2'b10
    } t_state;

    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(DEPTH);

    t_state            r_state;
    t_state            n_state;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    t_status           r_status;
    t_status           n_status;
    logic              r_rd_ok;
    logic              n_rd_ok;
    logic [POS_W-1:0]  r_pos;

    logic              r_m_valid;
    t_status           r_m_status;
    logic [DATA_W-1:0] r_m_read;
    logic [DATA_W-1:0] r_m_front;
    logic [DATA_W-1:0] r_m_back;
    logic [FILL_W-1:0] r_m_count;
    logic              r_m_is_empty;

    logic              w_in_xfer;
    logic              w_out_load;
    t_kind             w_kind;
    logic [DATA_W-1:0] w_push_value;
    logic [POS_W-1:0]  w_pos;
    t_cell_ctrl        w_ctrl;
    t_sel_ctrl         w_sel;
    logic [DATA_W-1:0] w_read_sum;
    logic [DATA_W-1:0] w_back_sum;

    logic [DATA_W-1:0] w_cell_data [DEPTH];
    logic [DATA_W-1:0] w_read_tap  [DEPTH];
    logic [DATA_W-1:0] w_back_tap  [DEPTH];

    // Unpack the input transfer
    assign w_kind       = t_kind'(s_axis_tdata[2:0]);
    assign w_push_value = s_axis_tdata[34:3];
    assign w_pos        = s_axis_tdata[38:35];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_SEL) && (!r_m_valid || m_axis_tready);

    // Decode operation against the current count
    always_comb begin
        n_fill            = r_fill;
        n_status          = ST_OK;
        n_rd_ok           = 1'b0;
        w_ctrl.shift_up   = 1'b0;
        w_ctrl.shift_down = 1'b0;
        w_ctrl.load_back  = 1'b0;
        w_ctrl.fill       = r_fill;
        case (w_kind)
            KIND_PUSH_BACK: begin
                if (r_fill >= DEPTH_F) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.load_back = w_in_xfer;
                    n_fill           = r_fill + 1'b1;
                end
            end
            KIND_PUSH_FRONT: begin
                if (r_fill >= DEPTH_F) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.shift_up = w_in_xfer;
                    n_fill          = r_fill + 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_fill = r_fill - 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.shift_down = w_in_xfer;
                    n_fill            = r_fill - 1'b1;
                end
            end
            KIND_READ_POS: begin
                if ({1'b0, w_pos} >= r_fill) begin
                    n_status = ST_RANGE;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequence: accept, then build the result
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_fill <= n_fill;
            end
        end
    end

    // Hold the per-item result fields for the select cycle
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_status <= n_status;
            r_rd_ok  <= n_rd_ok;
            r_pos    <= w_pos;
        end
    end

    assign w_sel.rd_en = r_rd_ok;
    assign w_sel.pos   = r_pos;
    assign w_sel.fill  = r_fill;

    // Row of cells, each wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_push_value;
        end else begin : g_mid
            assign w_prev = w_cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_cell_data[g];
        end else begin : g_inner
            assign w_next = w_cell_data[g+1];
        end
        rbd_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_sel        (w_sel),
            .i_push_value (w_push_value),
            .i_prev_data  (w_prev),
            .i_next_data  (w_next),
            .o_data       (w_cell_data[g]),
            .o_read_tap   (w_read_tap[g]),
            .o_back_tap   (w_back_tap[g])
        );
    end

    // Merge the one-hot taps
    always_comb begin
        w_read_sum = '0;
        w_back_sum = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_read_sum = w_read_sum | w_read_tap[i];
            w_back_sum = w_back_sum | w_back_tap[i];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_status   <= r_status;
            r_m_read     <= w_read_sum;
            r_m_front    <= (r_fill != '0) ? w_cell_data[0] : '0;
            r_m_back     <= w_back_sum;
            r_m_count    <= r_fill;
            r_m_is_empty <= (r_fill == '0);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_is_empty, r_m_count, r_m_back, r_m_front,
                            r_m_read, r_m_status};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_F)
        else $error("element count exceeds depth");

    a_xfer_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_SEL))
        else $error("transfer did not start result select");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_is_empty == (r_m_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_is_empty) |-> ((r_m_front == '0) && (r_m_back == '0)
                                         && (r_m_read == '0)))
        else $error("nonzero value on empty result");

    a_range_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_status != ST_OK)) |-> (r_m_read == '0))
        else $error("read value on refused operation");

endmodule
